FILE: rtl/core/circular_list_with_cursor_top_macros.svh
// Assertion macros used by the list manager checker
`ifndef CIRCULAR_LIST_WITH_CURSOR_TOP_MACROS_SVH
`define CIRCULAR_LIST_WITH_CURSOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CLL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list manager check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CLL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list manager check failed");

`endif

FILE: rtl/core/cll_pkg.sv
// Types and constants of the circular list manager
`default_nettype none

package cll_pkg;

    // CAPACITY must be a power of two: slot indexes wrap on SLOT_W bits
    localparam int CAPACITY = 256;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INS_BACK  = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_FIRST     = 3'd2,
        OP_NEXT      = 3'd3,
        OP_REMOVE    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOCURSOR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP1,
        S_STEP2,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic [1:0]                status;
        logic [COUNT_W-1:0]        count_out;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/cll_stream_if.sv
// Valid/ready channel carrying one payload beat
`default_nettype none

interface cll_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cll_ram.sv
// Simple dual-port RAM, one write and one registered read port
`default_nettype none

module cll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/circular_list_with_cursor_top.sv
// Circular linked list manager with cursor, built on slot memories
// Errors and unused ops answer from S_IDLE; remove and insert into an empty list finish
// in S_STEP1; other inserts and first and next finish in S_STEP2 (link read, then data read).
// One request in flight: req is taken only in S_IDLE, and a stalled rsp holds the result in S_HOLD.
// Reset (rst_n low, async) clears list control and free-stack valid bits; memories
// keep their contents and unwritten free-stack entries read as their initial slots.
`default_nettype none

module circular_list_with_cursor_top (
    input wire logic     clk,
    input wire logic     rst_n,
    cll_stream_if.sink   req,
    cll_stream_if.source rsp
);

    import cll_pkg::*;

    state_t                    state_reg,        state_next;
    logic [OP_W-1:0]           op_reg,           op_next;
    logic signed [VALUE_W-1:0] value_reg,        value_next;
    logic [SLOT_W-1:0]         tail_reg,         tail_next;
    logic [SLOT_W-1:0]         cursor_reg,       cursor_next;
    logic [SLOT_W-1:0]         before_reg,       before_next;
    logic [SLOT_W-1:0]         slot_reg,         slot_next;
    logic                      cvalid_reg,       cvalid_next;
    logic                      armed_reg,        armed_next;
    logic [COUNT_W-1:0]        count_reg,        count_next;
    logic signed [VALUE_W-1:0] res_value_reg,    res_value_next;
    status_t                   res_status_reg,   res_status_next;
    logic                      rsp_valid_reg,    rsp_valid_next;
    rsp_t                      rsp_data_reg,     rsp_data_next;

    logic [CAPACITY-1:0]       free_valid_reg;
    logic                      free_vq_reg;

    logic                      data_we;
    logic [SLOT_W-1:0]         data_waddr;
    logic [VALUE_W-1:0]        data_wdata;
    logic [SLOT_W-1:0]         data_raddr;
    logic [VALUE_W-1:0]        data_q;

    logic                      link_we;
    logic [SLOT_W-1:0]         link_waddr;
    logic [SLOT_W-1:0]         link_wdata;
    logic [SLOT_W-1:0]         link_raddr;
    logic [SLOT_W-1:0]         link_q;

    logic                      free_we;
    logic [SLOT_W-1:0]         free_waddr;
    logic [SLOT_W-1:0]         free_wdata;
    logic [SLOT_W-1:0]         free_q;

    logic [SLOT_W-1:0]         pop_addr;
    logic [SLOT_W-1:0]         push_addr;
    logic [SLOT_W-1:0]         new_slot;
    logic                      out_free;
    logic                      finish;
    logic signed [VALUE_W-1:0] res_value;
    status_t                   res_status;
    logic                      is_empty;
    logic                      is_full;

    cll_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_q)
    );

    cll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_q)
    );

    cll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (pop_addr),
        .rdata (free_q)
    );

    // top of free stack sits at CAPACITY - 1 - count; a push goes to CAPACITY - count (mod CAPACITY)
    assign pop_addr  = ~count_reg[SLOT_W-1:0];
    assign push_addr = SLOT_W'(0) - count_reg[SLOT_W-1:0];
    // an unwritten free-stack entry holds the slot equal to the count
    assign new_slot  = free_vq_reg ? free_q : count_reg[SLOT_W-1:0];
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == COUNT_W'(CAPACITY));

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        tail_next       = tail_reg;
        cursor_next     = cursor_reg;
        before_next     = before_reg;
        slot_next       = slot_reg;
        cvalid_next     = cvalid_reg;
        armed_next      = armed_reg;
        count_next      = count_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_data_next   = rsp_data_reg;

        data_we    = 1'b0;
        data_waddr = slot_reg;
        data_wdata = value_reg;
        data_raddr = cursor_reg;
        link_we    = 1'b0;
        link_waddr = slot_reg;
        link_wdata = slot_reg;
        link_raddr = tail_reg;
        free_we    = 1'b0;
        free_waddr = push_addr;
        free_wdata = cursor_reg;

        finish     = 1'b0;
        res_value  = '0;
        res_status = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                op_next    = req.data.op;
                value_next = req.data.value;
                if ((req.data.op == OP_NEXT) || (req.data.op == OP_REMOVE))
                begin
                    link_raddr = cursor_reg;
                end
                if (req.valid)
                begin
                    state_next = S_STEP1;
                    unique case (req.data.op)
                        OP_INS_BACK, OP_INS_FRONT:
                        begin
                            if (is_full)
                            begin
                                finish     = 1'b1;
                                res_status = ST_FULL;
                            end
                        end
                        OP_FIRST:
                        begin
                            if (is_empty)
                            begin
                                finish     = 1'b1;
                                res_status = ST_EMPTY;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (is_empty)
                            begin
                                finish     = 1'b1;
                                res_status = ST_EMPTY;
                            end
                            else if (!cvalid_reg)
                            begin
                                finish     = 1'b1;
                                res_status = ST_NOCURSOR;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                finish     = 1'b1;
                                res_status = ST_EMPTY;
                            end
                            else if (!cvalid_reg || !armed_reg)
                            begin
                                finish     = 1'b1;
                                res_status = ST_NOCURSOR;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_STEP1:
            begin
                unique case (op_reg)
                    OP_INS_BACK, OP_INS_FRONT:
                    begin
                        data_we    = 1'b1;
                        data_waddr = new_slot;
                        data_wdata = value_reg;
                        link_we    = 1'b1;
                        link_waddr = new_slot;
                        link_wdata = is_empty ? new_slot : link_q;
                        slot_next  = new_slot;
                        count_next = count_reg + COUNT_W'(1);
                        armed_next = 1'b0;
                        if (is_empty)
                        begin
                            tail_next = new_slot;
                            finish    = 1'b1;
                        end
                        else
                        begin
                            state_next = S_STEP2;
                        end
                    end
                    OP_FIRST:
                    begin
                        before_next = tail_reg;
                        cursor_next = link_q;
                        cvalid_next = 1'b1;
                        armed_next  = 1'b1;
                        data_raddr  = link_q;
                        state_next  = S_STEP2;
                    end
                    OP_NEXT:
                    begin
                        before_next = cursor_reg;
                        cursor_next = link_q;
                        armed_next  = 1'b1;
                        data_raddr  = link_q;
                        state_next  = S_STEP2;
                    end
                    OP_REMOVE:
                    begin
                        res_value = data_q;
                        if ((cursor_reg == tail_reg) && (link_q != cursor_reg))
                        begin
                            tail_next = before_reg;
                        end
                        link_we     = 1'b1;
                        link_waddr  = before_reg;
                        link_wdata  = link_q;
                        cursor_next = before_reg;
                        free_we     = 1'b1;
                        free_waddr  = push_addr;
                        free_wdata  = cursor_reg;
                        count_next  = count_reg - COUNT_W'(1);
                        armed_next  = 1'b0;
                        if (count_reg == COUNT_W'(1))
                        begin
                            cvalid_next = 1'b0;
                        end
                        finish = 1'b1;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_STEP2:
            begin
                unique case (op_reg)
                    OP_INS_BACK, OP_INS_FRONT:
                    begin
                        link_we    = 1'b1;
                        link_waddr = tail_reg;
                        link_wdata = slot_reg;
                        if (op_reg == OP_INS_BACK)
                        begin
                            tail_next = slot_reg;
                        end
                        finish = 1'b1;
                    end
                    OP_FIRST, OP_NEXT:
                    begin
                        res_value = data_q;
                        finish    = 1'b1;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            S_HOLD:
            begin
                res_value  = res_value_reg;
                res_status = res_status_reg;
                finish     = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            if (out_free)
            begin
                rsp_valid_next          = 1'b1;
                rsp_data_next.value_out = res_value;
                rsp_data_next.status    = res_status;
                rsp_data_next.count_out = count_next;
                state_next              = S_IDLE;
            end
            else
            begin
                res_value_next  = res_value;
                res_status_next = res_status;
                state_next      = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tail_reg       <= '0;
            cursor_reg     <= '0;
            before_reg     <= '0;
            cvalid_reg     <= 1'b0;
            armed_reg      <= 1'b0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            free_valid_reg <= '0;
            free_vq_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tail_reg      <= tail_next;
            cursor_reg    <= cursor_next;
            before_reg    <= before_next;
            cvalid_reg    <= cvalid_next;
            armed_reg     <= armed_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            free_vq_reg   <= free_valid_reg[pop_addr];
            if (free_we)
            begin
                free_valid_reg[free_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        slot_reg       <= slot_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        rsp_data_reg   <= rsp_data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/cll_checker.sv
// Port-level checks of the list manager, bound to the top level
`default_nettype none
`include "circular_list_with_cursor_top_macros.svh"

module cll_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire cll_pkg::rsp_t rsp_data
);

    import cll_pkg::*;

    `CLL_ASSERT_IMPL(a_count_range, rsp_valid, rsp_data.count_out <= COUNT_W'(CAPACITY))
    `CLL_ASSERT_IMPL(a_full_count,
        rsp_valid && (rsp_data.status == ST_FULL),
        (rsp_data.count_out == COUNT_W'(CAPACITY)) && (rsp_data.value_out == '0))
    `CLL_ASSERT_IMPL(a_empty_count,
        rsp_valid && (rsp_data.status == ST_EMPTY),
        (rsp_data.count_out == '0) && (rsp_data.value_out == '0))
    `CLL_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready || rsp_valid)
    `CLL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind circular_list_with_cursor_top cll_checker u_cll_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
